FILE: hdl/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types and constants of the cardinal spline tessellator.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int COORD_WIDTH    = 32;
  localparam int TENSION_WIDTH  = 15;
  localparam int STEP_WIDTH     = 16;
  localparam int CFG_DATA_WIDTH = 16;
  localparam int CFG_IDX_WIDTH  = 1;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_TENSION = 1'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_T_STEP  = 1'd1;

  localparam logic [TENSION_WIDTH-1:0] TENSION_RESET = 15'd8192;
  localparam logic [STEP_WIDTH-1:0]    T_STEP_RESET  = 16'd4096;
  localparam logic [STEP_WIDTH-1:0]    MIN_STEP      = 16'd1024;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // one window of four control points, index 3 is the newest
  typedef struct packed {
    coord_t [3:0] x;
    coord_t [3:0] y;
    coord_t [3:0] z;
  } seg_t;

endpackage

FILE: hdl/cst_front.sv
// ----------------------------------------------------------------------------
// cst_front
// Takes control points, keeps the last three of a curve and hands each
// complete window of four to the segment queue.
// ----------------------------------------------------------------------------
module cst_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  cst_pkg::coord_t       point_x,
  input  cst_pkg::coord_t       point_y,
  input  cst_pkg::coord_t       point_z,
  input  logic                  start_curve,
  input  logic                  queue_full,
  output logic                  push,
  output cst_pkg::seg_t         seg
);

  logic [1:0]      held;
  logic [1:0]      held_eff;
  logic            accept;
  cst_pkg::coord_t wx [3];
  cst_pkg::coord_t wy [3];
  cst_pkg::coord_t wz [3];

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;
  assign held_eff = start_curve ? 2'd0 : held;
  assign push     = accept && (held_eff == 2'd3);

  always_comb begin
    seg.x = {point_x, wx[2], wx[1], wx[0]};
    seg.y = {point_y, wy[2], wy[1], wy[0]};
    seg.z = {point_z, wz[2], wz[1], wz[0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 2'd0;
    end else if (accept && held_eff != 2'd3) begin
      held <= held_eff + 2'd1;
    end else if (accept) begin
      held <= held_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (held_eff != 2'd3) begin
        wx[held_eff] <= point_x;
        wy[held_eff] <= point_y;
        wz[held_eff] <= point_z;
      end else begin
        // slide the window by one point
        wx[0] <= wx[1]; wx[1] <= wx[2]; wx[2] <= point_x;
        wy[0] <= wy[1]; wy[1] <= wy[2]; wy[2] <= point_y;
        wz[0] <= wz[1]; wz[1] <= wz[2]; wz[2] <= point_z;
      end
    end
  end

endmodule

FILE: hdl/cst_queue.sv
// ----------------------------------------------------------------------------
// cst_queue
// Two-entry queue of segment windows between front and evaluator.
// ----------------------------------------------------------------------------
module cst_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cst_pkg::seg_t push_seg,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output cst_pkg::seg_t head
);

  cst_pkg::seg_t entry [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_seg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count beyond depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("pop from empty queue");

endmodule

FILE: hdl/cst_back.sv
// ----------------------------------------------------------------------------
// cst_back
// Sequenced evaluator: for the window at the queue head it steps t and runs
// each sample through square, cube, weight, round, multiply and sum steps.
// ----------------------------------------------------------------------------
module cst_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  seg_valid,
  input  cst_pkg::seg_t                         seg,
  output logic                                  pop,
  input  logic [cst_pkg::TENSION_WIDTH-1:0]     tension,
  input  logic [cst_pkg::STEP_WIDTH-1:0]        t_step,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output cst_pkg::coord_t                       sample_x,
  output cst_pkg::coord_t                       sample_y,
  output cst_pkg::coord_t                       sample_z,
  output cst_pkg::coord_t                       slope_x,
  output cst_pkg::coord_t                       slope_y,
  output cst_pkg::coord_t                       slope_z,
  output logic [cst_pkg::STEP_WIDTH-1:0]        t_value,
  output logic                                  final_sample
);

  localparam int CW     = cst_pkg::COORD_WIDTH;
  localparam int PW     = 38;             // polynomial in Q.32
  localparam int VW     = 54;             // weight before rounding, Q.46
  localparam int WW     = 32;             // weight, Q.24
  localparam int MW     = WW + CW;        // one product
  localparam int AW     = MW + 2;         // sum of four products
  localparam int SW     = cst_pkg::STEP_WIDTH;

  localparam logic [2:0] PH_SQUARE = 3'd0;
  localparam logic [2:0] PH_CUBE   = 3'd1;
  localparam logic [2:0] PH_POLY   = 3'd2;
  localparam logic [2:0] PH_ROUND  = 3'd3;
  localparam logic [2:0] PH_MUL    = 3'd4;
  localparam logic [2:0] PH_SUM    = 3'd5;

  localparam logic signed [PW-1:0] ONE    = PW'(64'sd1 <<< 32);
  localparam logic signed [VW-1:0] W_RND  = VW'(64'sd1 <<< 21);
  localparam logic signed [AW-1:0] O_RND  = AW'(64'sd1 <<< 23);
  localparam logic signed [AW-1:0] O_MAX  = AW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [AW-1:0] O_MIN  = -O_MAX - AW'(1);

  logic          busy;
  logic [2:0]    phase;
  logic [SW-1:0] u;
  logic [SW-1:0] step;
  logic [SW:0]   u_sum;
  logic          last;
  logic          load;
  logic [31:0]   t2;
  logic [31:0]   t3;
  logic [47:0]   cube;

  // polynomial step
  logic signed [PW-1:0] t1s, t2s, t3s;
  logic signed [PW-1:0] b1, b2, db1, db2, a2, a3, da2;
  logic signed [VW-1:0] s_w, b1_w, b2_w, db1_w, db2_w, a2_w, a3_w, da2_w;
  logic signed [VW-1:0] sb1, sb2, sdb1, sdb2;
  logic signed [VW-1:0] v_next [8];
  logic signed [VW-1:0] v      [8];
  logic signed [VW-1:0] v_rnd  [8];
  logic signed [WW-1:0] w      [8];
  logic signed [MW-1:0] pp     [6][4];
  logic signed [CW-1:0] cx     [4];
  logic signed [CW-1:0] cy     [4];
  logic signed [CW-1:0] cz     [4];
  logic signed [AW-1:0] acc    [6];
  logic signed [AW-1:0] res    [6];
  logic signed [CW-1:0] sat    [6];

  assign step  = (t_step < cst_pkg::MIN_STEP) ? cst_pkg::MIN_STEP : t_step;
  assign u_sum = {1'b0, u} + {1'b0, step};
  assign last  = u_sum[SW];
  assign load  = busy && (phase == PH_SUM) && (!out_valid || !out_stall);
  assign pop   = load && last;
  assign cube  = {16'd0, u} * {16'd0, t2};

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      cx[j] = $signed(seg.x[j]);
      cy[j] = $signed(seg.y[j]);
      cz[j] = $signed(seg.z[j]);
    end
  end

  always_comb begin
    t1s  = $signed({6'd0, u, 16'd0});
    t2s  = $signed({6'd0, t2});
    t3s  = $signed({6'd0, t3});
    b1   = -t3s + (t2s <<< 1) - t1s;
    b2   = -t3s + t2s;
    db1  = -(t2s * 3) + (t1s <<< 2) - ONE;
    db2  = -(t2s * 3) + (t1s <<< 1);
    a2   = (t3s <<< 1) - (t2s * 3) + ONE;
    a3   = ONE - a2;
    da2  = (t2s * 6) - (t1s * 6);
  end

  assign s_w   = VW'($signed({1'b0, tension}));
  assign b1_w  = VW'(b1);
  assign b2_w  = VW'(b2);
  assign db1_w = VW'(db1);
  assign db2_w = VW'(db2);
  assign a2_w  = VW'(a2);
  assign a3_w  = VW'(a3);
  assign da2_w = VW'(da2);
  assign sb1   = s_w * b1_w;
  assign sb2   = s_w * b2_w;
  assign sdb1  = s_w * db1_w;
  assign sdb2  = s_w * db2_w;

  always_comb begin
    // the mirrored weights share products with opposite sign
    v_next[0] = sb1;
    v_next[1] = (a2_w <<< 14) + sb2;
    v_next[2] = (a3_w <<< 14) - sb1;
    v_next[3] = -sb2;
    v_next[4] = sdb1;
    v_next[5] = (da2_w <<< 14) + sdb2;
    v_next[6] = -(da2_w <<< 14) - sdb1;
    v_next[7] = -sdb2;
    for (int i = 0; i < 8; i++) begin
      v_rnd[i] = (v[i] + W_RND) >>> 22;
    end
  end

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      acc[k] = AW'(pp[k][0]) + AW'(pp[k][1]) + AW'(pp[k][2]) + AW'(pp[k][3]);
      res[k] = (acc[k] + O_RND) >>> 24;
      if (res[k] > O_MAX) begin
        sat[k] = O_MAX[CW-1:0];
      end else if (res[k] < O_MIN) begin
        sat[k] = O_MIN[CW-1:0];
      end else begin
        sat[k] = res[k][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      PH_SQUARE: begin
        t2 <= {16'd0, u} * {16'd0, u};
      end
      PH_CUBE: begin
        t3 <= 32'((cube + 48'd32768) >> 16);
      end
      PH_POLY: begin
        for (int i = 0; i < 8; i++) begin
          v[i] <= v_next[i];
        end
      end
      PH_ROUND: begin
        for (int i = 0; i < 8; i++) begin
          w[i] <= v_rnd[i][WW-1:0];
        end
      end
      PH_MUL: begin
        for (int j = 0; j < 4; j++) begin
          pp[0][j] <= w[j] * cx[j];
          pp[1][j] <= w[j] * cy[j];
          pp[2][j] <= w[j] * cz[j];
          pp[3][j] <= w[j+4] * cx[j];
          pp[4][j] <= w[j+4] * cy[j];
          pp[5][j] <= w[j+4] * cz[j];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= PH_SQUARE;
      u     <= '0;
    end else if (!busy) begin
      if (seg_valid) begin
        busy  <= 1'b1;
        phase <= PH_SQUARE;
        u     <= '0;
      end
    end else begin
      case (phase)
        PH_SQUARE: phase <= PH_CUBE;
        PH_CUBE:   phase <= PH_POLY;
        PH_POLY:   phase <= PH_ROUND;
        PH_ROUND:  phase <= PH_MUL;
        PH_MUL:    phase <= PH_SUM;
        PH_SUM: begin
          if (load) begin
            phase <= PH_SQUARE;
            u     <= u_sum[SW-1:0];
            if (last) begin
              busy <= 1'b0;
            end
          end
        end
        default: phase <= PH_SQUARE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sample_x     <= sat[0];
      sample_y     <= sat[1];
      sample_z     <= sat[2];
      slope_x      <= sat[3];
      slope_y      <= sat[4];
      slope_z      <= sat[5];
      t_value      <= u;
      final_sample <= last;
    end
  end

  a_pop_busy: assert property (@(posedge clk) disable iff (rst) pop |-> seg_valid)
    else $error("window retired with empty queue");
  a_idle_after_pop: assert property (@(posedge clk) disable iff (rst) pop |=> !busy)
    else $error("evaluator still busy after last sample");
  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst) load |=> out_valid)
    else $error("sample lost at output register");

endmodule

FILE: hdl/cardinal_spline_tessellator.sv
// ----------------------------------------------------------------------------
// cardinal_spline_tessellator
// Cardinal spline tessellation of a stream of 3-D control points.
// ----------------------------------------------------------------------------
// The first three points of a curve are only held and give no words. Every
// later point closes a window of four and yields ceil(65536 / step) sample
// words (16 at the reset step). When idle, the evaluator picks up the window
// at the queue head and runs each sample through the square, cube, weight,
// round, multiply and sum steps; the sum step waits while the output stalls.
// A two-window queue lets points be taken while the evaluator works;
// configuration must be written while the block is idle.
module cardinal_spline_tessellator (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [cst_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
  input  logic [cst_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  cst_pkg::coord_t                      point_x,
  input  cst_pkg::coord_t                      point_y,
  input  cst_pkg::coord_t                      point_z,
  input  logic                                 start_curve,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output cst_pkg::coord_t                      sample_x,
  output cst_pkg::coord_t                      sample_y,
  output cst_pkg::coord_t                      sample_z,
  output cst_pkg::coord_t                      slope_x,
  output cst_pkg::coord_t                      slope_y,
  output cst_pkg::coord_t                      slope_z,
  output logic [cst_pkg::STEP_WIDTH-1:0]       t_value,
  output logic                                 final_sample
);

  logic [cst_pkg::TENSION_WIDTH-1:0] tension;
  logic [cst_pkg::STEP_WIDTH-1:0]    t_step;
  logic                              push;
  logic                              pop;
  logic                              full;
  logic                              empty;
  cst_pkg::seg_t                     push_seg;
  cst_pkg::seg_t                     head;

  always_ff @(posedge clk) begin
    if (rst) begin
      tension <= cst_pkg::TENSION_RESET;
      t_step  <= cst_pkg::T_STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cst_pkg::REG_TENSION: tension <= cfg_data[cst_pkg::TENSION_WIDTH-1:0];
        cst_pkg::REG_T_STEP:  t_step  <= cfg_data[cst_pkg::STEP_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  cst_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .start_curve (start_curve),
    .queue_full  (full),
    .push        (push),
    .seg         (push_seg)
  );

  cst_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_seg (push_seg),
    .pop      (pop),
    .full     (full),
    .empty    (empty),
    .head     (head)
  );

  cst_back u_back (
    .clk          (clk),
    .rst          (rst),
    .seg_valid    (!empty),
    .seg          (head),
    .pop          (pop),
    .tension      (tension),
    .t_step       (t_step),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample_x     (sample_x),
    .sample_y     (sample_y),
    .sample_z     (sample_z),
    .slope_x      (slope_x),
    .slope_y      (slope_y),
    .slope_z      (slope_z),
    .t_value      (t_value),
    .final_sample (final_sample)
  );

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cardinal spline tessellator: feeds control point
// streams under several tension and step settings and checks every sample
// word against a bit-exact fixed-point predictor of the curve arithmetic.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  SETTLE_CYCLES = 500;
  localparam int  CYCLE_LIMIT   = 1500000;
  localparam int  NUM_PHASES    = 7;
  localparam longint T_ONE      = 65536;
  localparam int  MAX_SAMPLES   = 64;
  localparam cst_pkg::coord_t C_MAX = 32'sh7fffffff;
  localparam cst_pkg::coord_t C_MIN = 32'sh80000000;

  typedef logic [cst_pkg::CFG_DATA_WIDTH-1:0] cfg_word_t;
  typedef logic [cst_pkg::CFG_IDX_WIDTH-1:0]  cfg_idx_t;
  typedef logic [cst_pkg::STEP_WIDTH-1:0]     step_t;

  typedef struct {
    cst_pkg::coord_t     pos_x, pos_y, pos_z;
    cst_pkg::coord_t     der_x, der_y, der_z;
    step_t               t;
    logic                last;
  } sample_t;

  typedef struct {
    cst_pkg::coord_t x, y, z;
    logic   sc;
    logic   pin;
    cst_pkg::coord_t ex, ey, ez;
  } point_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  cfg_idx_t  cfg_index = cst_pkg::REG_TENSION;
  cfg_word_t cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  cst_pkg::coord_t point_x = '0, point_y = '0, point_z = '0;
  logic start_curve = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  cst_pkg::coord_t sample_x, sample_y, sample_z, slope_x, slope_y, slope_z;
  step_t t_value;
  logic final_sample;

  cardinal_spline_tessellator i_dut (.*);

  // predictor state
  logic [cst_pkg::TENSION_WIDTH-1:0] cur_tension = cst_pkg::TENSION_RESET;
  step_t                             cur_step    = cst_pkg::T_STEP_RESET;
  cst_pkg::coord_t held_x[3], held_y[3], held_z[3];
  int     held_count = 0;

  sample_t pending_samples[$];
  int  errors = 0;
  int  send_idle_pct = 0, recv_idle_pct = 0;
  logic rx_hold = 1'b0;
  int  cycles = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("cardinal_spline_tessellator regression: fail");
      $finish;
    end
  end

  function automatic longint mk_weight(longint a, longint b, longint s);
    return (a * 16384 + s * b + (64'sd1 <<< 21)) >>> 22;
  endfunction

  function automatic cst_pkg::coord_t blend(longint w[4], cst_pkg::coord_t c0,
                                            cst_pkg::coord_t c1, cst_pkg::coord_t c2,
                                            cst_pkg::coord_t c3);
    longint acc;
    acc = w[0] * longint'(c0) + w[1] * longint'(c1) + w[2] * longint'(c2)
        + w[3] * longint'(c3);
    acc = (acc + (64'sd1 <<< 23)) >>> 24;
    if (acc > longint'(C_MAX)) acc = C_MAX;
    if (acc < longint'(C_MIN)) acc = C_MIN;
    return cst_pkg::coord_t'(acc);
  endfunction

  function automatic void queue_sample(sample_t smp);
    pending_samples.insert(pending_samples.size(), smp);
  endfunction

  // takes one control point, appends the sample words it yields
  function automatic void predict_segment_samples(cst_pkg::coord_t px, cst_pkg::coord_t py,
                                                  cst_pkg::coord_t pz, logic sc);
    longint s, u, stp, t1, t2, t3, one;
    longint bw[4], dw[4];
    int n;
    sample_t smp;
    s = cur_tension;
    stp = (cur_step < cst_pkg::MIN_STEP) ? cst_pkg::MIN_STEP : cur_step;
    one = 64'sd1 <<< 32;
    n = 0;
    if (sc) held_count = 0;
    if (held_count < 3) begin
      held_x[held_count] = px;
      held_y[held_count] = py;
      held_z[held_count] = pz;
      held_count++;
      return;
    end
    for (u = 0; u < T_ONE && n < MAX_SAMPLES; u += stp) begin
      t1 = u <<< 16;
      t2 = u * u;
      t3 = (u * u * u + 32768) >>> 16;
      bw[0] = mk_weight(0, -t3 + 2*t2 - t1, s);
      bw[1] = mk_weight(2*t3 - 3*t2 + one, -t3 + t2, s);
      bw[2] = mk_weight(-2*t3 + 3*t2, t3 - 2*t2 + t1, s);
      bw[3] = mk_weight(0, t3 - t2, s);
      dw[0] = mk_weight(0, -3*t2 + 4*t1 - one, s);
      dw[1] = mk_weight(6*t2 - 6*t1, -3*t2 + 2*t1, s);
      dw[2] = mk_weight(-6*t2 + 6*t1, 3*t2 - 4*t1 + one, s);
      dw[3] = mk_weight(0, 3*t2 - 2*t1, s);
      smp.pos_x = blend(bw, held_x[0], held_x[1], held_x[2], px);
      smp.pos_y = blend(bw, held_y[0], held_y[1], held_y[2], py);
      smp.pos_z = blend(bw, held_z[0], held_z[1], held_z[2], pz);
      smp.der_x = blend(dw, held_x[0], held_x[1], held_x[2], px);
      smp.der_y = blend(dw, held_y[0], held_y[1], held_y[2], py);
      smp.der_z = blend(dw, held_z[0], held_z[1], held_z[2], pz);
      smp.t     = u[cst_pkg::STEP_WIDTH-1:0];
      smp.last  = (u + stp >= T_ONE);
      queue_sample(smp);
      n++;
    end
    held_x[0] = held_x[1]; held_x[1] = held_x[2]; held_x[2] = px;
    held_y[0] = held_y[1]; held_y[1] = held_y[2]; held_y[2] = py;
    held_z[0] = held_z[1]; held_z[1] = held_z[2]; held_z[2] = pz;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // output side: stall at negedge, compare at posedge
  always @(negedge clk) begin
    out_stall <= rx_hold || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    sample_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("unexpected word", sample_x, 0);
      end else begin
        e = pending_samples.pop_front();
        if (sample_x !== e.pos_x) report_mismatch("sample_x", sample_x, e.pos_x);
        if (sample_y !== e.pos_y) report_mismatch("sample_y", sample_y, e.pos_y);
        if (sample_z !== e.pos_z) report_mismatch("sample_z", sample_z, e.pos_z);
        if (slope_x !== e.der_x) report_mismatch("slope_x", slope_x, e.der_x);
        if (slope_y !== e.der_y) report_mismatch("slope_y", slope_y, e.der_y);
        if (slope_z !== e.der_z) report_mismatch("slope_z", slope_z, e.der_z);
        if (t_value !== e.t) report_mismatch("t_value", t_value, e.t);
        if (final_sample !== e.last) report_mismatch("final_sample", final_sample, e.last);
      end
    end
  end

  // called right after a negedge, returns right after a negedge
  task automatic send_point(point_row_t r);
    int base;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    point_x = r.x;
    point_y = r.y;
    point_z = r.z;
    start_curve = r.sc;
    do @(posedge clk); while (in_stall);
    base = pending_samples.size();
    predict_segment_samples(r.x, r.y, r.z, r.sc);
    if (r.pin) begin
      // at t = 0 the curve sits exactly on the second point of the window
      pending_samples[base].pos_x = r.ex;
      pending_samples[base].pos_y = r.ey;
      pending_samples[base].pos_z = r.ez;
    end
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_word_t val);
    in_valid = 1'b0;
    wait (pending_samples.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == cst_pkg::REG_TENSION) cur_tension = val[cst_pkg::TENSION_WIDTH-1:0];
    else cur_step = val;
  endtask

  function automatic cst_pkg::coord_t pick_coord();
    case ($urandom_range(9))
      0: return C_MAX;
      1: return C_MIN;
      2, 3, 4: return cst_pkg::coord_t'($urandom);
      default: return cst_pkg::coord_t'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  point_row_t directed_rows[] = '{
    '{32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b0, 0, 0, 0},
    '{C_MAX, C_MIN, 32'sd0, 1'b0, 1'b0, 0, 0, 0},
    '{32'sd65536, -32'sd65536, 32'sd1, 1'b0, 1'b0, 0, 0, 0},
    '{C_MIN, C_MAX, -32'sd1, 1'b0, 1'b1, C_MAX, C_MIN, 32'sd0},
    '{C_MAX, C_MAX, C_MAX, 1'b0, 1'b1, 32'sd65536, -32'sd65536, 32'sd1},
    '{C_MIN, C_MIN, C_MIN, 1'b0, 1'b1, C_MIN, C_MAX, -32'sd1},
    '{32'sd1, 32'sd2, 32'sd3, 1'b1, 1'b0, 0, 0, 0},
    '{32'sd4, 32'sd5, 32'sd6, 1'b0, 1'b0, 0, 0, 0},
    '{32'sd7, 32'sd8, 32'sd9, 1'b1, 1'b0, 0, 0, 0},
    '{32'sd10, 32'sd11, 32'sd12, 1'b0, 1'b0, 0, 0, 0},
    '{32'sd13, 32'sd14, 32'sd15, 1'b0, 1'b0, 0, 0, 0},
    '{32'sh12345678, -32'sh0abcdef0, 32'sh00fff000, 1'b0, 1'b1, 32'sd10, 32'sd11,
      32'sd12},
    '{-32'sd65536, 32'sd131072, C_MAX, 1'b0, 1'b1, 32'sd13, 32'sd14, 32'sd15},
    '{32'sh55555555, 32'sh2aaaaaaa, -32'sh55555555, 1'b0, 1'b0, 0, 0, 0},
    '{C_MAX, C_MAX, C_MAX, 1'b1, 1'b0, 0, 0, 0},
    '{C_MAX, C_MAX, C_MAX, 1'b0, 1'b0, 0, 0, 0},
    '{C_MAX, C_MAX, C_MAX, 1'b0, 1'b0, 0, 0, 0},
    '{C_MAX, C_MAX, C_MAX, 1'b0, 1'b1, C_MAX, C_MAX, C_MAX},
    '{C_MIN, C_MIN, C_MIN, 1'b0, 1'b0, 0, 0, 0}
  };

  int phase_tension[NUM_PHASES] = '{8192, 0, 32767, 5000, 20000, 8192, 16384};
  int phase_step[NUM_PHASES]    = '{4096, 65535, 0, 1024, 3000, 7777, 20000};
  int phase_items[NUM_PHASES]   = '{80, 70, 20, 15, 96, 100, 60};
  int phase_send[NUM_PHASES]    = '{9, 9, 86, 86, 86, 0, 0};
  int phase_recv[NUM_PHASES]    = '{86, 86, 9, 9, 9, 0, 0};

  initial begin
    point_row_t r;
    int left_in_curve;
    left_in_curve = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct = phase_send[p];
      recv_idle_pct = phase_recv[p];
      if (p > 0) begin
        write_reg(cst_pkg::REG_TENSION, cfg_word_t'(phase_tension[p]));
        write_reg(cst_pkg::REG_T_STEP, cfg_word_t'(phase_step[p]));
      end
      if (p == 0) begin
        foreach (directed_rows[i]) send_point(directed_rows[i]);
      end
      if (p == 5) begin
        // long receiver hold-off so the window queue fills and input stalls
        fork
          begin
            rx_hold = 1'b1;
            repeat (3000) @(negedge clk);
            rx_hold = 1'b0;
          end
        join_none
      end
      for (int i = 0; i < phase_items[p]; i++) begin
        r.x = pick_coord();
        r.y = pick_coord();
        r.z = pick_coord();
        r.pin = 1'b0;
        if (left_in_curve == 0) begin
          r.sc = 1'b1;
          left_in_curve = ($urandom_range(9) == 0) ? $urandom_range(1, 3)
                                                   : $urandom_range(4, 14);
        end else begin
          r.sc = ($urandom_range(49) == 0);
        end
        left_in_curve--;
        send_point(r);
      end
    end
    in_valid = 1'b0;
    wait (pending_samples.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("cardinal_spline_tessellator regression: pass");
    end else begin
      $display("cardinal_spline_tessellator regression: fail");
    end
    $finish;
  end

endmodule
